FILE: rtl/multicart_address_latch_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multicart address latch mapper
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTICART_ADDRESS_LATCH_MAPPER_CORE_ASSERT_SVH
`define MULTICART_ADDRESS_LATCH_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCALM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCALM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcalm_pkg.sv
// ----------------------------------------------------------------------------
// mcalm_pkg
// Types and constants for the multicart address latch mapper.
// ----------------------------------------------------------------------------
package mcalm_pkg;

    localparam int OFFSET_FULL_W = 30;   // 16-bit bank field + 14-bit window
    localparam int PRG_OFFSET_W  = 21;

    localparam logic       MODE_WRITE   = 1'b1;
    localparam logic [3:0] PAGE_SCRATCH = 4'h5;

    // cpu_address bit positions
    localparam int ADDR_ROM_BIT     = 15;
    localparam int ADDR_SCRATCH_BIT = 11;
    localparam int ADDR_KEEP_BIT    = 8;

    // latched_address bit positions
    localparam int LATCH_BANK16_BIT = 7;
    localparam int LATCH_PAD_BIT    = 6;

    typedef enum logic [1:0] {
        SRC_OPEN_BUS = 2'd0,
        SRC_SCRATCH  = 2'd1,
        SRC_PRG_ROM  = 2'd2,
        SRC_NONE     = 2'd3
    } src_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]              read_data;
        src_t                    data_source;
        logic [PRG_OFFSET_W-1:0] prg_rom_offset;
        logic [7:0]              chr_bank;
        logic                    mirror_horizontal;
    } res_t;

endpackage

FILE: rtl/mcalm_map.sv
// ----------------------------------------------------------------------------
// mcalm_map
// Bank state (latched address/data, scratch bytes) and the per-access decode.
// ----------------------------------------------------------------------------
module mcalm_map #(
    parameter int PRG_ADDR_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  mcalm_pkg::req_t req,
    input  logic [3:0]      dip_setting,
    output mcalm_pkg::res_t res
);
    import mcalm_pkg::*;

    localparam logic [OFFSET_FULL_W-1:0] WRAP_MASK =
        OFFSET_FULL_W'((64'd1 << PRG_ADDR_BITS) - 64'd1);

    logic [15:0] latched_address_reg, latched_address_next;
    logic [7:0]  latched_data_reg, latched_data_next;
    logic [7:0]  scratch_reg [4];
    logic        scratch_we;

    logic                     is_write;
    logic                     is_scratch_page;
    logic                     is_rom;
    logic [15:0]              rom_addr;
    logic [OFFSET_FULL_W-1:0] off_full;

    always_comb
    begin
        is_write        = (req.mode == MODE_WRITE);
        is_scratch_page = (req.cpu_address[15:12] == PAGE_SCRATCH);
        is_rom          = req.cpu_address[ADDR_ROM_BIT];

        // pad mode: DIP value replaces the low nibble
        rom_addr = latched_address_reg[LATCH_PAD_BIT] ?
                   {req.cpu_address[15:4], dip_setting} : req.cpu_address;
        off_full = latched_address_reg[LATCH_BANK16_BIT] ?
                   {latched_address_reg, rom_addr[13:0]} :
                   {latched_address_reg[15:1], rom_addr[14:0]};

        latched_address_next = latched_address_reg;
        latched_data_next    = latched_data_reg;
        scratch_we           = 1'b0;
        res.read_data        = 8'd0;
        res.data_source      = SRC_NONE;
        res.prg_rom_offset   = '0;

        if (is_write)
        begin
            if (is_scratch_page)
            begin
                scratch_we = req.cpu_address[ADDR_SCRATCH_BIT];
            end
            else if (is_rom)
            begin
                if (req.cpu_address[ADDR_KEEP_BIT])
                begin
                    latched_data_next = {latched_data_reg[7:2], req.write_data[1:0]};
                end
                else
                begin
                    latched_address_next = req.cpu_address;
                    latched_data_next    = req.write_data;
                end
            end
        end
        else
        begin
            if (is_scratch_page)
            begin
                if (req.cpu_address[ADDR_SCRATCH_BIT])
                begin
                    res.read_data   = scratch_reg[req.cpu_address[1:0]];
                    res.data_source = SRC_SCRATCH;
                end
                else
                begin
                    res.data_source = SRC_OPEN_BUS;
                end
            end
            else if (is_rom)
            begin
                res.data_source    = SRC_PRG_ROM;
                res.prg_rom_offset = PRG_OFFSET_W'(off_full & WRAP_MASK);
            end
        end

        res.chr_bank          = latched_data_next;
        res.mirror_horizontal = latched_data_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_address_reg <= 16'd0;
            latched_data_reg    <= 8'd0;
            for (int i = 0; i < 4; i++)
            begin
                scratch_reg[i] <= 8'd0;
            end
        end
        else if (fire)
        begin
            latched_address_reg <= latched_address_next;
            latched_data_reg    <= latched_data_next;
            if (scratch_we)
            begin
                scratch_reg[req.cpu_address[1:0]] <= req.write_data;
            end
        end
    end

endmodule

FILE: rtl/multicart_address_latch_mapper_core.sv
// A request accepted into the input register moves to the result register, which
// drives out_valid. One request per cycle unless out_ready stalls; the two registers
// form a two-stage pipeline that advances whenever the result register is free.
// Reset (rst_n low, asynchronous): latched address/data, scratch bytes and the
// DIP setting clear to zero and both pipeline stages empty.
// ----------------------------------------------------------------------------
// multicart_address_latch_mapper_core
// Cartridge banking logic: one CPU bus access in, one mapping result out.
// ----------------------------------------------------------------------------
module multicart_address_latch_mapper_core #(
    parameter int PRG_ADDR_BITS = 21
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [1:0]  data_source,
    output logic [20:0] prg_rom_offset,
    output logic [7:0]  chr_bank,
    output logic        mirror_horizontal,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_wdata
);
    import mcalm_pkg::*;

    logic       req_valid_reg;
    req_t       req_reg;
    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic [3:0] dip_setting_reg;
    logic       out_free;
    logic       advance;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = req_valid_reg && out_free;
    assign in_ready  = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;

    mcalm_map #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .req         (req_reg),
        .dip_setting (dip_setting_reg),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            dip_setting_reg <= 4'd0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= req_valid_reg;
            end
            if (cfg_valid)
            begin
                dip_setting_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.mode        <= mode;
            req_reg.cpu_address <= cpu_address;
            req_reg.write_data  <= write_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = res_reg.read_data;
    assign data_source       = res_reg.data_source;
    assign prg_rom_offset    = res_reg.prg_rom_offset;
    assign chr_bank          = res_reg.chr_bank;
    assign mirror_horizontal = res_reg.mirror_horizontal;

endmodule

FILE: rtl/mcalm_checker.sv
// ----------------------------------------------------------------------------
// mcalm_checker
// Port-level checks on the mapper result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "multicart_address_latch_mapper_core_assert.svh"

module mcalm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic [1:0]  data_source,
    input logic [20:0] prg_rom_offset,
    input logic [7:0]  chr_bank,
    input logic        mirror_horizontal
);
    import mcalm_pkg::*;

    // only ROM reads carry an offset
    `MCALM_ASSERT_IMPLY(a_offset_rom_only, clk, rst_n, out_valid && (data_source != SRC_PRG_ROM), prg_rom_offset == 21'd0, "offset set on a non-ROM result")

    // only scratch reads return data
    `MCALM_ASSERT_IMPLY(a_read_data_scratch_only, clk, rst_n, out_valid && (data_source != SRC_SCRATCH), read_data == 8'd0, "read data set on a non-scratch result")

    // mirroring follows the CHR bank top bit
    `MCALM_ASSERT_IMPLY(a_mirror_matches_chr, clk, rst_n, out_valid, mirror_horizontal == chr_bank[7], "mirroring disagrees with CHR bank")

    `MCALM_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(chr_bank) && $stable(prg_rom_offset), "stalled result changed")

endmodule

bind multicart_address_latch_mapper_core mcalm_checker u_mcalm_checker (.*);

FILE: tb/tb_multicart_address_latch_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_multicart_address_latch_mapper_core
// Self-checking bench for the multicart banking core. It sends directed and
// random CPU bus requests with bursty timing and a stalling result side. Every
// result is checked field by field against an in-bench model of the banking
// state. The DIP setting is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_multicart_address_latch_mapper_core;

    timeunit 1ns;
    timeprecision 1ps;

    import mcalm_pkg::*;

    localparam int   PRG_BITS    = 21;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   MAX_REPORTS = 100;
    localparam logic MODE_READ   = 1'b0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [15:0] cpu_address = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic [1:0]  data_source;
    logic [20:0] prg_rom_offset;
    logic [7:0]  chr_bank;
    logic        mirror_horizontal;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_wdata = '0;

    // bank state as the core should hold it
    logic [3:0]  dip_sw = '0;
    logic [15:0] latch_addr = '0;
    logic [7:0]  latch_data = '0;
    logic [7:0]  scratch_mem [4] = '{default: '0};

    req_t pending_accesses [$];
    res_t expected_results [$];

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    multicart_address_latch_mapper_core #(
        .PRG_ADDR_BITS(PRG_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .cpu_address      (cpu_address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .data_source      (data_source),
        .prg_rom_offset   (prg_rom_offset),
        .chr_bank         (chr_bank),
        .mirror_horizontal(mirror_horizontal),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_wdata        (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Applies one bus access to the bank state and returns the mapped result.
    function automatic res_t bus_access_result(input req_t acc);
        res_t r;
        logic [15:0] a;
        logic [OFFSET_FULL_W-1:0] off;
        a = acc.cpu_address;
        r = '0;
        r.data_source = SRC_NONE;
        if (acc.mode == MODE_WRITE) begin
            if (a[15:12] == PAGE_SCRATCH) begin
                if (a[ADDR_SCRATCH_BIT])
                    scratch_mem[a[1:0]] = acc.write_data;
            end
            else if (a[ADDR_ROM_BIT]) begin
                if (a[ADDR_KEEP_BIT]) begin
                    latch_data[1:0] = acc.write_data[1:0];
                end
                else begin
                    latch_addr = a;
                    latch_data = acc.write_data;
                end
            end
        end
        else if (a[15:12] == PAGE_SCRATCH) begin
            if (a[ADDR_SCRATCH_BIT]) begin
                r.read_data = scratch_mem[a[1:0]];
                r.data_source = SRC_SCRATCH;
            end
            else begin
                r.data_source = SRC_OPEN_BUS;
            end
        end
        else if (a[ADDR_ROM_BIT]) begin
            r.data_source = SRC_PRG_ROM;
            if (latch_addr[LATCH_PAD_BIT])
                a[3:0] = dip_sw;
            if (latch_addr[LATCH_BANK16_BIT])
                off = {latch_addr, a[13:0]};
            else
                off = {latch_addr[15:1], a[14:0]};
            off = off & ((30'd1 << PRG_BITS) - 30'd1);
            r.prg_rom_offset = off[PRG_OFFSET_W-1:0];
        end
        r.chr_bank = latch_data;
        r.mirror_horizontal = latch_data[7];
        return r;
    endfunction

    function automatic req_t random_access();
        req_t r;
        int pick;
        logic [3:0] page;
        pick = $urandom_range(0, 99);
        r.mode = MODE_READ;
        r.cpu_address = 16'($urandom_range(0, 65535));
        r.write_data = 8'($urandom_range(0, 255));
        if (pick < 25) begin
            // bank select write
            r.mode = MODE_WRITE;
            r.cpu_address[ADDR_ROM_BIT] = 1'b1;
            r.cpu_address[ADDR_KEEP_BIT] = 1'b0;
        end
        else if (pick < 35) begin
            // low data bits only
            r.mode = MODE_WRITE;
            r.cpu_address[ADDR_ROM_BIT] = 1'b1;
            r.cpu_address[ADDR_KEEP_BIT] = 1'b1;
        end
        else if (pick < 65) begin
            r.cpu_address[ADDR_ROM_BIT] = 1'b1;
        end
        else if (pick < 85) begin
            r.mode = 1'($urandom_range(0, 1));
            r.cpu_address[15:12] = PAGE_SCRATCH;
            r.cpu_address[ADDR_SCRATCH_BIT] = 1'b1;
        end
        else if (pick < 90) begin
            r.mode = 1'($urandom_range(0, 1));
            r.cpu_address[15:12] = PAGE_SCRATCH;
            r.cpu_address[ADDR_SCRATCH_BIT] = 1'b0;
        end
        else begin
            r.mode = 1'($urandom_range(0, 1));
            page = 4'($urandom_range(0, 6));
            if (page == PAGE_SCRATCH)
                page = 4'h7;
            r.cpu_address[15:12] = page;
        end
        return r;
    endfunction

    task automatic push_access(input logic m, input logic [15:0] a, input logic [7:0] d);
        req_t r;
        r.mode = m;
        r.cpu_address = a;
        r.write_data = d;
        pending_accesses.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [31:0] want, got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    // sampled mid-cycle so the clocked blocks have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_dip(input logic [3:0] value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dip_sw = value;
    endtask

    // request side: bursts of random length, random gaps in between
    always @(posedge clk or negedge rst_n) begin
        req_t nxt;
        logic launch;
        if (!rst_n) begin
            in_valid <= 1'b0;
            mode <= 1'b0;
            cpu_address <= '0;
            write_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                nxt.mode = mode;
                nxt.cpu_address = cpu_address;
                nxt.write_data = write_data;
                expected_results.push_back(bus_access_result(nxt));
            end
            if (!in_valid || in_ready) begin
                launch = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_accesses.size() != 0) begin
                    nxt = pending_accesses.pop_front();
                    mode <= nxt.mode;
                    cpu_address <= nxt.cpu_address;
                    write_data <= nxt.write_data;
                    launch = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else begin
                        burst_left <= burst_left - 1;
                    end
                end
                in_valid <= launch;
            end
        end
    end

    // result side: check, then pick the next ready value from the stall pattern
    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with no request pending", $time);
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("data_source", want.data_source, data_source);
                    check_field("prg_rom_offset", want.prg_rom_offset, prg_rom_offset);
                    check_field("chr_bank", want.chr_bank, chr_bank);
                    check_field("mirror_horizontal", want.mirror_horizontal,
                                mirror_horizontal);
                end
            end
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(32, 300);
            end
            else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (stall_left % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_dip(4'hA);
        // latch is zero: 32K bank 0
        push_access(MODE_READ,  16'h8000, 8'hFF);
        push_access(MODE_READ,  16'hFFFF, 8'h00);
        // scratch bytes
        push_access(MODE_WRITE, 16'h5800, 8'hFF);
        push_access(MODE_WRITE, 16'h5803, 8'h5A);
        push_access(MODE_READ,  16'h5800, 8'h00);
        push_access(MODE_READ,  16'h5FFF, 8'hFF);
        push_access(MODE_READ,  16'h5000, 8'h00);
        push_access(MODE_WRITE, 16'h57FF, 8'h12);
        push_access(MODE_READ,  16'h5801, 8'h00);
        // bit 8 set: only data bits 1..0 change
        push_access(MODE_WRITE, 16'hFFFF, 8'hFF);
        push_access(MODE_WRITE, 16'hFEFF, 8'hFF);
        push_access(MODE_READ,  16'h8123, 8'h00);
        push_access(MODE_WRITE, 16'h8100, 8'h00);
        // 16K banks, no pad
        push_access(MODE_WRITE, 16'h8080, 8'h81);
        push_access(MODE_READ,  16'hC567, 8'h00);
        // 32K banks with pad
        push_access(MODE_WRITE, 16'h8040, 8'h7E);
        push_access(MODE_READ,  16'hABCD, 8'h00);
        push_access(MODE_WRITE, 16'hFE3F, 8'h00);
        push_access(MODE_READ,  16'hFFFF, 8'h00);
        // nothing mapped here, then a final bank select write
        push_access(MODE_WRITE, 16'h0000, 8'hFF);
        push_access(MODE_READ,  16'h0000, 8'h00);
        push_access(MODE_WRITE, 16'h7FFF, 8'hAA);
        push_access(MODE_READ,  16'h4FFF, 8'h00);
        push_access(MODE_READ,  16'h6000, 8'h00);
        push_access(MODE_WRITE, 16'h8000, 8'h00);

        for (int p = 0; p < 8; p++) begin
            if (p == 0)
                write_dip(4'hF);
            else if (p == 1)
                write_dip(4'h0);
            else
                write_dip(4'($urandom_range(0, 15)));
            repeat (200) pending_accesses.push_back(random_access());
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
